// File: sv/vts_pkg.sv
// ============================================================================
// vts_pkg
// Shared types, constants and helper functions of the VRML97 token scanner.
// ============================================================================
`default_nettype none

package vts_pkg;

    localparam int LINE_BITS_DEF   = 20;
    localparam int COLUMN_BITS_DEF = 16;
    localparam int MAX_KEYWORD_LEN = 12;
    localparam int NUM_WORDS       = 34;
    localparam int NUM_KEYWORDS    = 14;

    // result field widths
    localparam int KIND_W = 6;
    localparam int OLINE_W = 20;
    localparam int OCOL_W = 16;
    localparam int LEN_W = 16;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // token kinds
    localparam logic [KIND_W-1:0] K_END         = 6'd0;
    localparam logic [KIND_W-1:0] K_PERIOD      = 6'd1;
    localparam logic [KIND_W-1:0] K_LBRACKET    = 6'd2;
    localparam logic [KIND_W-1:0] K_RBRACKET    = 6'd3;
    localparam logic [KIND_W-1:0] K_LBRACE      = 6'd4;
    localparam logic [KIND_W-1:0] K_RBRACE      = 6'd5;
    localparam logic [KIND_W-1:0] K_ID          = 6'd6;
    localparam logic [KIND_W-1:0] K_INT         = 6'd7;
    localparam logic [KIND_W-1:0] K_REAL        = 6'd8;
    localparam logic [KIND_W-1:0] K_STRING      = 6'd9;
    localparam logic [KIND_W-1:0] K_KEYWORD0    = 6'd10;
    localparam logic [KIND_W-1:0] K_FIELDTYPE0  = 6'd24;
    localparam logic [KIND_W-1:0] K_UNKNOWN     = 6'd44;
    localparam logic [KIND_W-1:0] K_OPEN_STRING = 6'd45;

    // byte codes
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_UE     = 8'h45;
    localparam logic [7:0] CH_UX     = 8'h58;
    localparam logic [7:0] CH_LBRK   = 8'h5b;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_RBRK   = 8'h5d;
    localparam logic [7:0] CH_LE     = 8'h65;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_DEL    = 8'h7f;

    // keyword-ids in order 0..13, field types 14..33; text right-aligned
    localparam logic [8*MAX_KEYWORD_LEN-1:0] WORD_TEXT [NUM_WORDS] = '{
        "DEF", "eventIn", "eventOut", "exposedField", "EXTERNPROTO", "FALSE",
        "field", "IS", "NULL", "PROTO", "ROUTE", "TO", "TRUE", "USE",
        "SFBool", "SFColor", "SFFloat", "SFImage", "SFInt32", "SFNode",
        "SFRotation", "SFString", "SFTime", "SFVec2f", "SFVec3f", "MFColor",
        "MFFloat", "MFInt32", "MFNode", "MFRotation", "MFString", "MFTime",
        "MFVec2f", "MFVec3f"
    };
    localparam logic [7:0] WORD_LEN [NUM_WORDS] = '{
        8'd3, 8'd7, 8'd8, 8'd12, 8'd11, 8'd5, 8'd5, 8'd2, 8'd4, 8'd5, 8'd5, 8'd2,
        8'd4, 8'd3, 8'd6, 8'd7, 8'd7, 8'd7, 8'd7, 8'd6, 8'd10, 8'd8, 8'd6, 8'd7,
        8'd7, 8'd7, 8'd7, 8'd7, 8'd6, 8'd10, 8'd8, 8'd6, 8'd7, 8'd7
    };
    // keywords that open a field-type expectation
    localparam int W_EVENTIN = 1;
    localparam int W_EVENTOUT = 2;
    localparam int W_EXPOSED = 3;
    localparam int W_FIELD = 6;

    typedef enum logic [3:0] {
        M_IDLE, M_COMMENT, M_IDENT, M_SIGN, M_INT_FIRST, M_INT, M_HEX,
        M_FRAC, M_EXP_MARK, M_EXP_DIGITS, M_DOT, M_STRING
    } scan_mode_t;

    typedef struct packed {
        logic [LEN_W-1:0]   length;
        logic [OCOL_W-1:0]  column;
        logic [OLINE_W-1:0] line;
        logic [KIND_W-1:0]  kind;
        logic               last;
    } token_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              want_type;
    } class_t;

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return is_digit(b) || (b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66);
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == CH_CR || b == CH_LF || b == CH_SPACE || b == CH_TAB || b == CH_COMMA;
    endfunction

    function automatic logic is_id_rest(input logic [7:0] b);
        return !(b <= CH_SPACE || b == CH_QUOTE || b == CH_HASH || b == CH_APOS ||
                 b == CH_COMMA || b == CH_DOT || b == CH_LBRK || b == CH_BSLASH ||
                 b == CH_RBRK || b == CH_LBRACE || b == CH_RBRACE || b == CH_DEL);
    endfunction

    function automatic logic is_id_first(input logic [7:0] b);
        return is_id_rest(b) && !is_digit(b) && b != CH_PLUS && b != CH_MINUS;
    endfunction

    // drop candidates whose character at position p differs from b
    function automatic logic [NUM_WORDS-1:0] narrow(input logic [NUM_WORDS-1:0] kc,
                                                    input logic [LEN_W-1:0] p,
                                                    input logic [7:0] b);
        logic [NUM_WORDS-1:0] r;
        int idx;
        r = kc;
        for (int w = 0; w < NUM_WORDS; w++) begin
            if (p >= LEN_W'(WORD_LEN[w])) begin
                r[w] = 1'b0;
            end else begin
                idx = int'(WORD_LEN[w]) - 1 - int'(p[7:0]);
                if (WORD_TEXT[w][8*idx +: 8] != b) r[w] = 1'b0;
            end
        end
        return r;
    endfunction

    // identifier kind from surviving candidates and final length
    function automatic class_t classify(input logic [NUM_WORDS-1:0] kc,
                                        input logic [LEN_W-1:0] len,
                                        input logic expecting);
        class_t c;
        c.kind = K_ID;
        c.want_type = 1'b0;
        for (int w = 0; w < NUM_WORDS; w++) begin
            if (kc[w] && LEN_W'(WORD_LEN[w]) == len) begin
                if (w < NUM_KEYWORDS) begin
                    c.kind = K_KEYWORD0 + KIND_W'(w);
                    if (w == W_EVENTIN || w == W_EVENTOUT || w == W_EXPOSED ||
                        w == W_FIELD) c.want_type = 1'b1;
                end else if (expecting) begin
                    c.kind = K_FIELDTYPE0 + KIND_W'(w - NUM_KEYWORDS);
                end
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: sv/vts_core.sv
// ============================================================================
// vts_core
// Scanner state and per-byte token logic; up to two tokens per beat.
// ============================================================================
`default_nettype none

module vts_core #(
    parameter int LINE_BITS   = vts_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = vts_pkg::COLUMN_BITS_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           step,
    input  wire logic [7:0]     in_byte,
    input  wire logic           end_of_input,
    output vts_pkg::token_t     tok0,
    output vts_pkg::token_t     tok1,
    output logic [1:0]          tok_count
);
    import vts_pkg::*;

    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;

    scan_mode_t             mode_reg, mode_next;
    logic [LINE_BITS-1:0]   line_reg, line_next, sline_reg, sline_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next, scol_reg, scol_next;
    logic [7:0]             prev_reg, prev_next;
    logic [LEN_W-1:0]       len_reg, len_next, len_grow;
    logic [NUM_WORDS-1:0]   kc_reg, kc_next;
    logic                   eft_reg, eft_next, esc_reg, esc_next;

    logic                   consumed, do_finish, do_idle, b_exp, b_nl;
    logic [KIND_W-1:0]      fin_kind, idle_kind;
    class_t                 cls;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            line_reg  <= LINE_BITS'(1);
            col_reg   <= '0;
            prev_reg  <= CH_SPACE;
            sline_reg <= '0;
            scol_reg  <= '0;
            len_reg   <= '0;
            kc_reg    <= '1;
            eft_reg   <= 1'b0;
            esc_reg   <= 1'b0;
        end else if (step) begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            prev_reg  <= prev_next;
            sline_reg <= sline_next;
            scol_reg  <= scol_next;
            len_reg   <= len_next;
            kc_reg    <= kc_next;
            eft_reg   <= eft_next;
            esc_reg   <= esc_next;
        end
    end

    assign len_grow = (len_reg < LEN_MAX) ? len_reg + 1'b1 : len_reg;
    assign b_exp    = in_byte == CH_UE || in_byte == CH_LE;
    assign b_nl     = in_byte == CH_LF || in_byte == CH_CR;
    assign cls      = classify(kc_reg, len_reg, eft_reg);

    // kind of the pending token when it is closed
    always_comb begin
        case (mode_reg)
            M_IDENT:                              fin_kind = cls.kind;
            M_SIGN:                               fin_kind = K_UNKNOWN;
            M_INT_FIRST, M_INT, M_HEX:            fin_kind = K_INT;
            M_FRAC, M_EXP_MARK, M_EXP_DIGITS:     fin_kind = K_REAL;
            M_DOT:                                fin_kind = K_PERIOD;
            M_STRING:                             fin_kind = K_OPEN_STRING;
            default:                              fin_kind = K_END;
        endcase
    end

    // one-byte token kind
    always_comb begin
        unique case (in_byte)
            CH_LBRK:   idle_kind = K_LBRACKET;
            CH_RBRK:   idle_kind = K_RBRACKET;
            CH_LBRACE: idle_kind = K_LBRACE;
            CH_RBRACE: idle_kind = K_RBRACE;
            default:   idle_kind = K_UNKNOWN;
        endcase
    end

    // per-beat scan step
    always_comb begin
        mode_next  = mode_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        prev_next  = prev_reg;
        sline_next = sline_reg;
        scol_next  = scol_reg;
        len_next   = len_reg;
        kc_next    = kc_reg;
        eft_next   = eft_reg;
        esc_next   = esc_reg;
        tok0       = '0;
        tok1       = '0;
        tok_count  = 2'd0;
        consumed   = 1'b1;
        do_finish  = 1'b0;
        do_idle    = 1'b0;

        if (end_of_input) begin
            do_finish = mode_reg != M_IDLE && mode_reg != M_COMMENT;
            mode_next = M_IDLE;
        end else begin
            prev_next = in_byte;
            if (col_reg < COL_MAX) col_next = col_reg + 1'b1;
            if (b_nl && !(in_byte == CH_LF && prev_reg == CH_CR)) begin
                if (line_reg < LINE_MAX) line_next = line_reg + 1'b1;
                col_next = '0;
            end
            case (mode_reg)
                M_COMMENT: begin
                    if (b_nl) mode_next = M_IDLE;
                end
                M_IDENT: begin
                    if (is_id_rest(in_byte)) begin
                        kc_next  = narrow(kc_reg, len_reg, in_byte);
                        len_next = len_grow;
                    end else consumed = 1'b0;
                end
                M_SIGN: begin
                    if (is_digit(in_byte)) begin
                        mode_next = M_INT_FIRST; len_next = len_grow;
                    end else if (in_byte == CH_DOT) begin
                        mode_next = M_DOT; len_next = len_grow;
                    end else consumed = 1'b0;
                end
                M_INT_FIRST, M_INT: begin
                    if (mode_reg == M_INT_FIRST && prev_reg == CH_ZERO &&
                        (in_byte == CH_LX || in_byte == CH_UX)) begin
                        mode_next = M_HEX; len_next = len_grow;
                    end else if (is_digit(in_byte)) begin
                        mode_next = M_INT; len_next = len_grow;
                    end else if (in_byte == CH_DOT) begin
                        mode_next = M_FRAC; len_next = len_grow;
                    end else if (b_exp) begin
                        mode_next = M_EXP_MARK; len_next = len_grow;
                    end else consumed = 1'b0;
                end
                M_HEX: begin
                    if (is_hex(in_byte)) len_next = len_grow;
                    else consumed = 1'b0;
                end
                M_FRAC: begin
                    if (is_digit(in_byte)) len_next = len_grow;
                    else if (b_exp) begin
                        mode_next = M_EXP_MARK; len_next = len_grow;
                    end else consumed = 1'b0;
                end
                M_EXP_MARK: begin
                    if (is_digit(in_byte) || in_byte == CH_PLUS || in_byte == CH_MINUS) begin
                        mode_next = M_EXP_DIGITS; len_next = len_grow;
                    end else consumed = 1'b0;
                end
                M_EXP_DIGITS: begin
                    if (is_digit(in_byte)) len_next = len_grow;
                    else consumed = 1'b0;
                end
                M_DOT: begin
                    if (is_digit(in_byte)) begin
                        mode_next = M_FRAC; len_next = len_grow;
                    end else consumed = 1'b0;
                end
                M_STRING: begin
                    len_next = len_grow;
                    if (esc_reg) esc_next = 1'b0;
                    else if (in_byte == CH_BSLASH) esc_next = 1'b1;
                    else if (in_byte == CH_QUOTE) begin
                        tok0 = '{length: len_grow, column: OCOL_W'(scol_reg),
                                 line: OLINE_W'(sline_reg), kind: K_STRING, last: 1'b0};
                        tok_count = 2'd1;
                        mode_next = M_IDLE;
                    end
                end
                default: do_idle = 1'b1;
            endcase
            if (!consumed) begin
                do_finish = 1'b1;
                do_idle   = 1'b1;
            end
        end

        // close the pending token
        if (do_finish) begin
            tok0 = '{length: len_reg, column: OCOL_W'(scol_reg),
                     line: OLINE_W'(sline_reg), kind: fin_kind, last: 1'b0};
            tok_count = 2'd1;
            mode_next = M_IDLE;
            if (mode_reg == M_IDENT) eft_next = cls.want_type;
        end

        if (end_of_input) begin
            // end token after any flushed one
            if (tok_count == 2'd0) begin
                tok0 = '{length: '0, column: OCOL_W'(col_reg),
                         line: OLINE_W'(line_reg), kind: K_END, last: 1'b0};
            end else begin
                tok1 = '{length: '0, column: OCOL_W'(col_reg),
                         line: OLINE_W'(line_reg), kind: K_END, last: 1'b0};
            end
            tok_count = tok_count + 2'd1;
        end else if (do_idle && !is_space(in_byte)) begin
            // fresh scan of this byte
            if (in_byte == CH_HASH) begin
                mode_next = M_COMMENT;
            end else if (in_byte == CH_QUOTE || is_id_first(in_byte) ||
                         in_byte == CH_PLUS || in_byte == CH_MINUS ||
                         is_digit(in_byte) || in_byte == CH_DOT) begin
                sline_next = line_next;
                scol_next  = col_next;
                len_next   = LEN_W'(1);
                if (in_byte == CH_QUOTE) begin
                    mode_next = M_STRING;
                    esc_next  = 1'b0;
                end else if (is_id_first(in_byte)) begin
                    mode_next = M_IDENT;
                    kc_next   = narrow('1, '0, in_byte);
                end else if (in_byte == CH_PLUS || in_byte == CH_MINUS) begin
                    mode_next = M_SIGN;
                end else if (is_digit(in_byte)) begin
                    mode_next = M_INT_FIRST;
                end else begin
                    mode_next = M_DOT;
                end
            end else begin
                if (tok_count == 2'd0) begin
                    tok0 = '{length: LEN_W'(1), column: OCOL_W'(col_next),
                             line: OLINE_W'(line_next), kind: idle_kind, last: 1'b0};
                end else begin
                    tok1 = '{length: LEN_W'(1), column: OCOL_W'(col_next),
                             line: OLINE_W'(line_next), kind: idle_kind, last: 1'b0};
                end
                tok_count = tok_count + 2'd1;
            end
        end

        tok0.last = tok_count == 2'd1;
        tok1.last = 1'b1;
    end

endmodule

`default_nettype wire

// File: sv/vrml97_token_scanner_top.sv
// ============================================================================
// vrml97_token_scanner_top
// VRML97 lexer: one text byte per beat in, tokens out.
// ============================================================================
// Takes one byte per clock while the queue has room and emits tokens (kind,
// start line, start column, length). A beat goes into an input register, is
// scanned from there and its zero, one or two tokens land in a four-entry
// output queue; a byte is taken every cycle as long as the queue keeps two
// free entries, so the sustained rate is one byte per cycle with at most one
// token per byte on average. tlast on the output marks the last token caused
// by one input beat.
`default_nettype none

module vrml97_token_scanner_top #(
    parameter int LINE_BITS   = vts_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = vts_pkg::COLUMN_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tuser,   // end_of_input
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // kind[5:0] line[25:6] column[41:26] length[57:42]
    output logic             m_tlast    // last
);
    import vts_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_eoi_reg;
    logic             fire, pop;
    token_t           tok0, tok1;
    logic [1:0]       tok_count;

    token_t           fifo_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   cnt_reg;

    // scan only when the queue has room for two tokens
    assign fire     = in_valid_reg && (cnt_reg <= (PTR_W+1)'(DEPTH - 2));
    assign s_tready = !in_valid_reg || fire;
    assign pop      = m_tvalid && m_tready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_eoi_reg  <= s_tuser;
        end
    end

    vts_core #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (fire),
        .in_byte      (in_byte_reg),
        .end_of_input (in_eoi_reg),
        .tok0         (tok0),
        .tok1         (tok1),
        .tok_count    (tok_count)
    );

    // token queue storage
    always_ff @(posedge aclk) begin
        if (fire && tok_count != 2'd0) fifo_mem[wr_ptr_reg] <= tok0;
        if (fire && tok_count == 2'd2) fifo_mem[wr_ptr_reg + 1'b1] <= tok1;
    end

    // token queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (fire) wr_ptr_reg <= wr_ptr_reg + PTR_W'(tok_count);
            if (pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_reg + (fire ? (PTR_W+1)'(tok_count) : '0)
                       - (PTR_W+1)'(pop);
        end
    end

    assign m_tvalid = cnt_reg != '0;
    assign m_tdata  = {6'd0, fifo_mem[rd_ptr_reg].length, fifo_mem[rd_ptr_reg].column,
                       fifo_mem[rd_ptr_reg].line, fifo_mem[rd_ptr_reg].kind};
    assign m_tlast  = fifo_mem[rd_ptr_reg].last;

    // checks
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (PTR_W+1)'(DEPTH)) else $error("token queue overflow");
    a_hold_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !fire |=> in_valid_reg) else $error("input beat lost");
    a_count_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_eoi_reg |-> tok_count != 2'd0) else $error("missing end token");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |=> cnt_reg <= (PTR_W+1)'(2)) else $error("queue count jump");

endmodule

`default_nettype wire

// File: bench/vrml97_token_scanner_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// vrml97_token_scanner_top_tb
// Self-checking bench for the VRML97 token scanner.
// ============================================================================
// A directed table of text bytes walks keywords, field types, numbers, strings,
// comments, line endings and end of input. After it come random VRML-like
// fragments mixed with raw noise bytes. A behavioral scanner predicts every
// token. Output beats are checked in order against the queue of predicted
// tokens. Both sides idle at random, and once the output side holds off long
// enough that the scanner has to stall its input.
`default_nettype none

module vrml97_token_scanner_top_tb;
    import vts_pkg::*;

    localparam int LINE_MAX = (1 << 20) - 1;
    localparam int COL_MAX = (1 << 16) - 1;

    typedef struct packed {
        logic [5:0]  kind;
        logic [19:0] line;
        logic [15:0] column;
        logic [15:0] length;
        logic        last;
    } tok_t;

    typedef struct {
        logic [7:0]  data;
        logic        eoi;
        logic        has_exp;
        tok_t        exp_tok;
    } stim_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;

    vrml97_token_scanner_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------- scanner predictor ----------------
    scan_mode_t        p_mode;
    int unsigned       p_line, p_col, p_sline, p_scol, p_len;
    logic [7:0]        p_prev;
    logic [NUM_WORDS-1:0] p_cand;
    logic              p_want_type, p_esc;
    tok_t              token_queue[$];
    tok_t              step_toks[$];
    int                errors = 0;

    string kw_names[NUM_WORDS] = '{
        "DEF", "eventIn", "eventOut", "exposedField", "EXTERNPROTO", "FALSE",
        "field", "IS", "NULL", "PROTO", "ROUTE", "TO", "TRUE", "USE",
        "SFBool", "SFColor", "SFFloat", "SFImage", "SFInt32", "SFNode",
        "SFRotation", "SFString", "SFTime", "SFVec2f", "SFVec3f", "MFColor",
        "MFFloat", "MFInt32", "MFNode", "MFRotation", "MFString", "MFTime",
        "MFVec2f", "MFVec3f"
    };

    function automatic bit b_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction
    function automatic bit b_hex(logic [7:0] b);
        return b_digit(b) || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
    endfunction
    function automatic bit b_space(logic [7:0] b);
        return b == CH_CR || b == CH_LF || b == CH_SPACE || b == CH_TAB || b == CH_COMMA;
    endfunction
    function automatic bit b_idrest(logic [7:0] b);
        return !(b <= CH_SPACE || b == CH_QUOTE || b == CH_HASH || b == CH_APOS ||
                 b == CH_COMMA || b == CH_DOT || b == CH_LBRK || b == CH_BSLASH ||
                 b == CH_RBRK || b == CH_LBRACE || b == CH_RBRACE || b == CH_DEL);
    endfunction
    function automatic bit b_idfirst(logic [7:0] b);
        return b_idrest(b) && !b_digit(b) && b != CH_PLUS && b != CH_MINUS;
    endfunction

    function automatic void push_tok(logic [5:0] k, int unsigned ln, int unsigned cl,
                                     int unsigned len);
        tok_t t;
        t.kind = k; t.line = ln[19:0]; t.column = cl[15:0]; t.length = len[15:0];
        t.last = 1'b0;
        step_toks.push_back(t);
    endfunction

    // drop keyword candidates that disagree with byte b at position p_len
    function automatic void cand_filter(logic [7:0] b);
        for (int w = 0; w < NUM_WORDS; w++)
            if (p_cand[w] && (p_len >= kw_names[w].len() || kw_names[w][p_len] != b))
                p_cand[w] = 1'b0;
    endfunction

    function automatic void grow_len();
        if (p_len < 16'hFFFF) p_len++;
    endfunction

    function automatic void open_tok(scan_mode_t m);
        p_mode = m; p_sline = p_line; p_scol = p_col; p_len = 1;
    endfunction

    function automatic void close_tok();
        logic [5:0] k;
        bit was;
        case (p_mode)
            M_IDENT: begin
                k = K_ID; was = p_want_type; p_want_type = 1'b0;
                for (int w = 0; w < NUM_WORDS; w++)
                    if (p_cand[w] && kw_names[w].len() == p_len) begin
                        if (w < NUM_KEYWORDS) begin
                            k = K_KEYWORD0 + 6'(w);
                            if (w == W_EVENTIN || w == W_EVENTOUT || w == W_EXPOSED ||
                                w == W_FIELD) p_want_type = 1'b1;
                        end else if (was) k = K_FIELDTYPE0 + 6'(w - NUM_KEYWORDS);
                    end
            end
            M_SIGN: k = K_UNKNOWN;
            M_INT_FIRST, M_INT, M_HEX: k = K_INT;
            M_FRAC, M_EXP_MARK, M_EXP_DIGITS: k = K_REAL;
            M_DOT: k = K_PERIOD;
            M_STRING: k = K_OPEN_STRING;
            default: begin
                p_mode = M_IDLE;
                return;
            end
        endcase
        push_tok(k, p_sline, p_scol, p_len);
        p_mode = M_IDLE;
    endfunction

    function automatic void scan_fresh(logic [7:0] b);
        logic [5:0] k;
        if (b_space(b)) return;
        if (b == CH_HASH) begin p_mode = M_COMMENT; return; end
        if (b == CH_QUOTE) begin open_tok(M_STRING); p_esc = 1'b0; return; end
        if (b_idfirst(b)) begin
            open_tok(M_IDENT);
            p_cand = '1; p_len = 0; cand_filter(b); p_len = 1;
            return;
        end
        if (b == CH_PLUS || b == CH_MINUS) begin open_tok(M_SIGN); return; end
        if (b_digit(b)) begin open_tok(M_INT_FIRST); return; end
        if (b == CH_DOT) begin open_tok(M_DOT); return; end
        case (b)
            CH_LBRK: k = K_LBRACKET;
            CH_RBRK: k = K_RBRACKET;
            CH_LBRACE: k = K_LBRACE;
            CH_RBRACE: k = K_RBRACE;
            default: k = K_UNKNOWN;
        endcase
        push_tok(k, p_line, p_col, 1);
    endfunction

    // returns 1 when b extends or belongs to the current token
    function automatic bit scan_cont(logic [7:0] b);
        bit ee;
        ee = (b == CH_UE || b == CH_LE);
        case (p_mode)
            M_COMMENT: begin
                if (b == CH_LF || b == CH_CR) p_mode = M_IDLE;
                return 1;
            end
            M_IDENT: begin
                if (!b_idrest(b)) return 0;
                cand_filter(b); grow_len(); return 1;
            end
            M_SIGN: begin
                if (b_digit(b)) begin p_mode = M_INT_FIRST; grow_len(); return 1; end
                if (b == CH_DOT) begin p_mode = M_DOT; grow_len(); return 1; end
                return 0;
            end
            M_INT_FIRST, M_INT: begin
                if (p_mode == M_INT_FIRST && p_prev == CH_ZERO && (b == CH_LX || b == CH_UX)) begin
                    p_mode = M_HEX; grow_len(); return 1;
                end
                p_mode = M_INT;
                if (b_digit(b)) begin grow_len(); return 1; end
                if (b == CH_DOT) begin p_mode = M_FRAC; grow_len(); return 1; end
                if (ee) begin p_mode = M_EXP_MARK; grow_len(); return 1; end
                return 0;
            end
            M_HEX: begin
                if (b_hex(b)) begin grow_len(); return 1; end
                return 0;
            end
            M_FRAC: begin
                if (b_digit(b)) begin grow_len(); return 1; end
                if (ee) begin p_mode = M_EXP_MARK; grow_len(); return 1; end
                return 0;
            end
            M_EXP_MARK: begin
                if (b_digit(b) || b == CH_PLUS || b == CH_MINUS) begin
                    p_mode = M_EXP_DIGITS; grow_len(); return 1;
                end
                return 0;
            end
            M_EXP_DIGITS: begin
                if (b_digit(b)) begin grow_len(); return 1; end
                return 0;
            end
            M_DOT: begin
                if (b_digit(b)) begin p_mode = M_FRAC; grow_len(); return 1; end
                return 0;
            end
            M_STRING: begin
                grow_len();
                if (p_esc) p_esc = 1'b0;
                else if (b == CH_BSLASH) p_esc = 1'b1;
                else if (b == CH_QUOTE) begin
                    push_tok(K_STRING, p_sline, p_scol, p_len);
                    p_mode = M_IDLE;
                end
                return 1;
            end
            default: begin
                p_mode = M_IDLE;
                scan_fresh(b);
                return 1;
            end
        endcase
    endfunction

    function automatic void scanner_reset();
        p_mode = M_IDLE; p_line = 1; p_col = 0; p_prev = CH_SPACE;
        p_sline = 0; p_scol = 0; p_len = 0; p_cand = '1;
        p_want_type = 1'b0; p_esc = 1'b0;
    endfunction

    // predict the tokens of one accepted beat; returns how many were queued
    function automatic int predict_tokens(logic [7:0] b, logic eoi);
        step_toks.delete();
        if (eoi) begin
            close_tok();
            push_tok(K_END, p_line, p_col, 0);
        end else begin
            if (p_col < COL_MAX) p_col++;
            if ((b == CH_LF || b == CH_CR) && !(b == CH_LF && p_prev == CH_CR)) begin
                if (p_line < LINE_MAX) p_line++;
                p_col = 0;
            end
            if (!scan_cont(b)) begin
                close_tok();
                scan_fresh(b);
            end
            p_prev = b;
        end
        foreach (step_toks[i]) begin
            step_toks[i].last = (i == step_toks.size() - 1);
            token_queue.push_back(step_toks[i]);
        end
        return step_toks.size();
    endfunction

    // ---------------- stimulus ----------------
    stim_t stim_list[$];
    int    tokens_seen = 0;
    bit    hold_off = 1'b0;
    bit    send_done = 1'b0;

    task automatic add_byte(logic [7:0] b);
        stim_t s;
        s.data = b; s.eoi = 1'b0; s.has_exp = 1'b0; s.exp_tok = '0;
        stim_list.push_back(s);
    endtask

    task automatic add_text(string t);
        for (int i = 0; i < t.len(); i++) add_byte(t[i]);
    endtask

    task automatic add_eoi();
        stim_t s;
        s.data = 8'($urandom); s.eoi = 1'b1; s.has_exp = 1'b0; s.exp_tok = '0;
        stim_list.push_back(s);
    endtask

    // directed rows whose token is obvious (end token right after reset, then a bracket), then directed text
    task automatic build_directed();
        stim_t s;
        s.data = 8'hFF; s.eoi = 1'b1; s.has_exp = 1'b1;
        s.exp_tok = '{kind: K_END, line: 20'd1, column: 16'd0, length: 16'd0, last: 1'b1};
        stim_list.push_back(s);
        s.data = CH_LBRK; s.eoi = 1'b0;
        s.exp_tok = '{kind: K_LBRACKET, line: 20'd1, column: 16'd1, length: 16'd1, last: 1'b1};
        stim_list.push_back(s);
        add_text("field SFVec3f x\r\n+.5e-3 0x1F -.\"a\\\"b\"#c\r");
        add_byte(8'h00); add_byte(8'hFF); add_byte(CH_DEL);
        add_text("\"open");
        add_eoi();
    endtask

    // one random VRML-ish fragment
    task automatic add_fragment();
        string num_pieces[8] = '{"0", "-12", "+3.25", "1e5", "2E+", ".7", "0Xbeef", "-."};
        string seps[6] = '{" ", "\n", "\r", "\r\n", ",", "\t"};
        case ($urandom_range(0, 9))
            0, 1: add_text(kw_names[$urandom_range(0, NUM_WORDS - 1)]);
            2: begin
                add_text(kw_names[$urandom_range(1, 6)]);
                add_text(" ");
                add_text(kw_names[$urandom_range(14, NUM_WORDS - 1)]);
            end
            3: add_text(num_pieces[$urandom_range(0, 7)]);
            4: begin
                add_byte(CH_QUOTE);
                repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(32, 126)));
                if ($urandom_range(0, 1)) add_text("\\\"");
                add_byte(CH_QUOTE);
            end
            5: add_text("# note\n");
            6: add_byte(8'($urandom));
            7: add_text("[{.}]");
            8: if ($urandom_range(0, 5) == 0) add_eoi(); else add_text("Ab9_z");
            default: repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(8'h80, 8'hFF)));
        endcase
        add_text(seps[$urandom_range(0, 5)]);
    endtask

    // ---------------- sender ----------------
    initial begin
        int gap;
        build_directed();
        while (stim_list.size() < 575) add_fragment();
        add_eoi();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        scanner_reset();
        foreach (stim_list[i]) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= stim_list[i].data;
            s_tuser <= stim_list[i].eoi;
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            if (predict_tokens(stim_list[i].data, stim_list[i].eoi) > 0 &&
                stim_list[i].has_exp && token_queue[$] != stim_list[i].exp_tok) begin
                $display("%0t: table row %0d expected %p got predicted %p", $time, i,
                         stim_list[i].exp_tok, token_queue[$]);
                errors++;
            end
        end
        s_tvalid <= 1'b0;
        send_done = 1'b1;
    end

    // ---------------- receiver ----------------
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            if (hold_off) gap = 0;
            else gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= !hold_off;
            @(posedge aclk);
        end
    end

    // long output stall once the stream is well under way
    initial begin
        wait (tokens_seen >= 60);
        @(posedge aclk);
        hold_off = 1'b1;
        repeat (80) @(posedge aclk);
        hold_off = 1'b0;
    end

    // ---------------- checker ----------------
    always @(posedge aclk) begin
        tok_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tdata[5:0]; got.line = m_tdata[25:6];
            got.column = m_tdata[41:26]; got.length = m_tdata[57:42];
            got.last = m_tlast;
            tokens_seen <= tokens_seen + 1;
            if (token_queue.size() == 0) begin
                $display("%0t: unexpected token %p", $time, got);
                errors++;
            end else begin
                want = token_queue.pop_front();
                if (got.kind != want.kind)
                    $display("%0t: kind expected %0d got %0d", $time, want.kind, got.kind);
                if (got.line != want.line)
                    $display("%0t: line expected %0d got %0d", $time, want.line, got.line);
                if (got.column != want.column)
                    $display("%0t: column expected %0d got %0d", $time, want.column,
                             got.column);
                if (got.length != want.length)
                    $display("%0t: length expected %0d got %0d", $time, want.length,
                             got.length);
                if (got.last != want.last)
                    $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
                if (got != want) errors++;
            end
        end
    end

    // ---------------- end of run ----------------
    initial begin
        @(posedge aresetn);
        wait (send_done);
        wait (token_queue.size() == 0);
        repeat (20) @(posedge aclk);
        if (errors == 0 && token_queue.size() == 0)
            $display("vrml97_token_scanner_top: match");
        else
            $display("vrml97_token_scanner_top: mismatch");
        $finish;
    end

    initial begin
        #500000;
        $display("vrml97_token_scanner_top: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
